// ===== hw/rtl/ppw_pkg.sv =====
// ----------------------------------------------------------------------------
// Projective point warp package
// Shared widths, register indexes, reset values and sideband types.
// ----------------------------------------------------------------------------
package ppw_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 32;

    localparam int COORD_W   = 32;
    localparam int COEF_W    = 48;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // Coefficients are split into an unsigned low part and a signed high part.
    localparam int MUL_LO_W = 32;
    localparam int MUL_HI_W = COEF_W - MUL_LO_W;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int NUM_W    = ACC_W + COORD_FRAC_BITS + 2;
    localparam int DEN_W    = ACC_W + 1;
    localparam int QUO_W    = COORD_W + 1;
    localparam int CMP_W    = DEN_W + QUO_W;
    localparam int PROD_N   = 6;

    localparam int MAC_LAT = 3;
    localparam int DIV_LAT = QUO_W + 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCALE_XX = 3'd0,
        REG_SHEAR_XY = 3'd1,
        REG_SHIFT_X  = 3'd2,
        REG_SHEAR_YX = 3'd3,
        REG_SCALE_YY = 3'd4,
        REG_SHIFT_Y  = 3'd5,
        REG_PERSP_X  = 3'd6,
        REG_PERSP_Y  = 3'd7
    } ppw_reg_t;

    typedef logic [REG_COUNT-1:0][COEF_W-1:0] coef_bank_t;

    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [COEF_W-1:0] COEF_ZERO = '0;
    localparam logic signed [ACC_W-1:0] W_ONE =
        ACC_W'(1) << (COEF_FRAC_BITS + COORD_FRAC_BITS);

    // Identity matrix, highest register index first: only the two scale
    // entries (indexes 4 and 0) are one.
    localparam coef_bank_t COEF_RESET = {COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE,
                                         COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE};

    localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic poly_end;
        logic bad;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } ppw_tag_t;

endpackage

// ===== hw/rtl/ppw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Projective point warp coefficient registers
// Eight write-only matrix coefficients with their reset values.
// ----------------------------------------------------------------------------
module ppw_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ppw_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [ppw_pkg::COEF_W-1:0]      cfg_wr_data,
    output ppw_pkg::coef_bank_t             coefs
);

    ppw_pkg::coef_bank_t coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= ppw_pkg::COEF_RESET;
        end else if (cfg_wr_en) begin
            coef_reg[cfg_index] <= cfg_wr_data;
        end
    end

    assign coefs = coef_reg;

endmodule

// ===== hw/rtl/ppw_mac.sv =====
// ----------------------------------------------------------------------------
// Projective point warp multiply-accumulate pipeline
// Three stages: partial products, full products, row sums X, Y and w.
// ----------------------------------------------------------------------------
module ppw_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [ppw_pkg::COORD_W-1:0]    x,
    input  logic signed [ppw_pkg::COORD_W-1:0]    y,
    input  logic                                  poly_end,
    input  ppw_pkg::coef_bank_t                   coefs,
    output logic                                  out_valid,
    output logic signed [ppw_pkg::ACC_W-1:0]      nx,
    output logic signed [ppw_pkg::ACC_W-1:0]      ny,
    output logic signed [ppw_pkg::ACC_W-1:0]      w,
    output logic                                  out_poly_end
);

    localparam int LO_PW = ppw_pkg::MUL_LO_W + 1 + ppw_pkg::COORD_W;
    localparam int HI_PW = ppw_pkg::MUL_HI_W + ppw_pkg::COORD_W;

    // Products in order: c0*x, c1*y, c3*x, c4*y, c6*x, c7*y.
    localparam ppw_pkg::ppw_reg_t PROD_COEF [ppw_pkg::PROD_N] = '{
        ppw_pkg::REG_SCALE_XX, ppw_pkg::REG_SHEAR_XY,
        ppw_pkg::REG_SHEAR_YX, ppw_pkg::REG_SCALE_YY,
        ppw_pkg::REG_PERSP_X,  ppw_pkg::REG_PERSP_Y
    };

    logic signed [LO_PW-1:0]            pl_reg   [ppw_pkg::PROD_N];
    logic signed [LO_PW-1:0]            pl_next  [ppw_pkg::PROD_N];
    logic signed [HI_PW-1:0]            ph_reg   [ppw_pkg::PROD_N];
    logic signed [HI_PW-1:0]            ph_next  [ppw_pkg::PROD_N];
    logic signed [ppw_pkg::PROD_W-1:0]  p_reg    [ppw_pkg::PROD_N];
    logic signed [ppw_pkg::PROD_W-1:0]  p_next   [ppw_pkg::PROD_N];
    logic signed [ppw_pkg::ACC_W-1:0]   nx_reg, ny_reg, w_reg;
    logic signed [ppw_pkg::ACC_W-1:0]   nx_next, ny_next, w_next;
    logic [ppw_pkg::MAC_LAT-1:0]        v_reg;
    logic [ppw_pkg::MAC_LAT-1:0]        pe_reg;

    always_comb begin
        for (int k = 0; k < ppw_pkg::PROD_N; k++) begin
            logic [ppw_pkg::COEF_W-1:0]         c;
            logic signed [ppw_pkg::COORD_W-1:0] opnd;
            c    = coefs[PROD_COEF[k]];
            opnd = (k % 2 == 0) ? x : y;
            pl_next[k] = $signed({1'b0, c[ppw_pkg::MUL_LO_W-1:0]}) * opnd;
            ph_next[k] = $signed(c[ppw_pkg::COEF_W-1:ppw_pkg::MUL_LO_W]) * opnd;
            p_next[k]  = (ppw_pkg::PROD_W'(ph_reg[k]) <<< ppw_pkg::MUL_LO_W)
                       + ppw_pkg::PROD_W'(pl_reg[k]);
        end
    end

    always_comb begin
        nx_next = ppw_pkg::ACC_W'(p_reg[0]) + ppw_pkg::ACC_W'(p_reg[1])
                + (ppw_pkg::ACC_W'($signed(coefs[ppw_pkg::REG_SHIFT_X]))
                   <<< ppw_pkg::COORD_FRAC_BITS);
        ny_next = ppw_pkg::ACC_W'(p_reg[2]) + ppw_pkg::ACC_W'(p_reg[3])
                + (ppw_pkg::ACC_W'($signed(coefs[ppw_pkg::REG_SHIFT_Y]))
                   <<< ppw_pkg::COORD_FRAC_BITS);
        w_next  = ppw_pkg::ACC_W'(p_reg[4]) + ppw_pkg::ACC_W'(p_reg[5]) + ppw_pkg::W_ONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[ppw_pkg::MAC_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pe_reg <= {pe_reg[ppw_pkg::MAC_LAT-2:0], poly_end};
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            p_reg  <= p_next;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            w_reg  <= w_next;
        end
    end

    assign out_valid    = v_reg[ppw_pkg::MAC_LAT-1];
    assign out_poly_end = pe_reg[ppw_pkg::MAC_LAT-1];
    assign nx           = nx_reg;
    assign ny           = ny_reg;
    assign w            = w_reg;

endmodule

// ===== hw/rtl/ppw_div.sv =====
// ----------------------------------------------------------------------------
// Projective point warp divider
// Pipelined restoring divide of X and Y by w, one quotient bit per stage,
// with rounding and saturation into Q16.16.
// ----------------------------------------------------------------------------
module ppw_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [ppw_pkg::ACC_W-1:0]      nx,
    input  logic signed [ppw_pkg::ACC_W-1:0]      ny,
    input  logic signed [ppw_pkg::ACC_W-1:0]      w,
    input  logic                                  poly_end,
    output logic                                  out_valid,
    output logic [ppw_pkg::COORD_W-1:0]           warped_x,
    output logic [ppw_pkg::COORD_W-1:0]           warped_y,
    output logic                                  out_poly_end,
    output logic                                  bad_divisor,
    output logic                                  clipped
);

    localparam int NST = ppw_pkg::QUO_W;

    // Stage A: magnitudes and divisor check.
    logic                          a_v_reg;
    logic [ppw_pkg::ACC_W-1:0]     a_mx_reg, a_my_reg, a_w_reg;
    ppw_pkg::ppw_tag_t             a_tag_reg;
    // Stage B: rounded dividends and doubled divisor.
    logic                          b_v_reg;
    logic [ppw_pkg::NUM_W-1:0]     b_nx_reg, b_ny_reg;
    logic [ppw_pkg::DEN_W-1:0]     b_d_reg;
    ppw_pkg::ppw_tag_t             b_tag_reg;
    // Quotient stages; entry 0 is the overflow check.
    logic                          s_v_reg   [NST+1];
    logic [ppw_pkg::NUM_W-1:0]     s_rx_reg  [NST+1];
    logic [ppw_pkg::NUM_W-1:0]     s_ry_reg  [NST+1];
    logic [ppw_pkg::QUO_W-1:0]     s_qx_reg  [NST+1];
    logic [ppw_pkg::QUO_W-1:0]     s_qy_reg  [NST+1];
    logic [ppw_pkg::DEN_W-1:0]     s_d_reg   [NST+1];
    ppw_pkg::ppw_tag_t             s_tag_reg [NST+1];
    // Output stage.
    logic                          o_v_reg;
    logic [ppw_pkg::COORD_W-1:0]   o_x_reg, o_y_reg, o_x_next, o_y_next;
    logic                          o_pe_reg, o_bad_reg, o_clip_reg, o_clip_next;

    ppw_pkg::ppw_tag_t             a_tag_next, ovf_tag;
    logic [ppw_pkg::CMP_W-1:0]     d_top;
    logic [ppw_pkg::QUO_W-1:0]     qx_f, qy_f;
    ppw_pkg::ppw_tag_t             tag_f;
    logic                          sat_x, sat_y;

    always_comb begin
        a_tag_next          = '0;
        a_tag_next.poly_end = poly_end;
        a_tag_next.bad      = w[ppw_pkg::ACC_W-1] || (w == '0);
        a_tag_next.neg_x    = nx[ppw_pkg::ACC_W-1];
        a_tag_next.neg_y    = ny[ppw_pkg::ACC_W-1];
    end

    always_comb begin
        d_top         = ppw_pkg::CMP_W'(b_d_reg) << ppw_pkg::QUO_W;
        ovf_tag       = b_tag_reg;
        ovf_tag.ovf_x = ppw_pkg::CMP_W'(b_nx_reg) >= d_top;
        ovf_tag.ovf_y = ppw_pkg::CMP_W'(b_ny_reg) >= d_top;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            s_v_reg[0] <= 1'b0;
            o_v_reg    <= 1'b0;
        end else if (en) begin
            a_v_reg    <= in_valid;
            b_v_reg    <= a_v_reg;
            s_v_reg[0] <= b_v_reg;
            o_v_reg    <= s_v_reg[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tag_reg    <= a_tag_next;
            a_mx_reg     <= nx[ppw_pkg::ACC_W-1] ? ppw_pkg::ACC_W'(-nx) : ppw_pkg::ACC_W'(nx);
            a_my_reg     <= ny[ppw_pkg::ACC_W-1] ? ppw_pkg::ACC_W'(-ny) : ppw_pkg::ACC_W'(ny);
            a_w_reg      <= w;
            b_tag_reg    <= a_tag_reg;
            b_nx_reg     <= (ppw_pkg::NUM_W'(a_mx_reg) << (ppw_pkg::COORD_FRAC_BITS + 1))
                          + ppw_pkg::NUM_W'(a_w_reg);
            b_ny_reg     <= (ppw_pkg::NUM_W'(a_my_reg) << (ppw_pkg::COORD_FRAC_BITS + 1))
                          + ppw_pkg::NUM_W'(a_w_reg);
            b_d_reg      <= {a_w_reg, 1'b0};
            s_tag_reg[0] <= ovf_tag;
            s_rx_reg[0]  <= b_nx_reg;
            s_ry_reg[0]  <= b_ny_reg;
            s_qx_reg[0]  <= '0;
            s_qy_reg[0]  <= '0;
            s_d_reg[0]   <= b_d_reg;
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar s = 0; s < NST; s++) begin : g_step
        localparam int SH = NST - 1 - s;
        logic [ppw_pkg::CMP_W-1:0] trial;
        logic                      bit_x, bit_y;
        logic [ppw_pkg::NUM_W-1:0] rx_next, ry_next;

        always_comb begin
            trial   = ppw_pkg::CMP_W'(s_d_reg[s]) << SH;
            bit_x   = ppw_pkg::CMP_W'(s_rx_reg[s]) >= trial;
            bit_y   = ppw_pkg::CMP_W'(s_ry_reg[s]) >= trial;
            rx_next = bit_x ? ppw_pkg::NUM_W'(ppw_pkg::CMP_W'(s_rx_reg[s]) - trial)
                            : s_rx_reg[s];
            ry_next = bit_y ? ppw_pkg::NUM_W'(ppw_pkg::CMP_W'(s_ry_reg[s]) - trial)
                            : s_ry_reg[s];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_v_reg[s+1] <= 1'b0;
            end else if (en) begin
                s_v_reg[s+1] <= s_v_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_rx_reg[s+1]  <= rx_next;
                s_ry_reg[s+1]  <= ry_next;
                s_qx_reg[s+1]  <= {s_qx_reg[s][ppw_pkg::QUO_W-2:0], bit_x};
                s_qy_reg[s+1]  <= {s_qy_reg[s][ppw_pkg::QUO_W-2:0], bit_y};
                s_d_reg[s+1]   <= s_d_reg[s];
                s_tag_reg[s+1] <= s_tag_reg[s];
            end
        end
    end

    always_comb begin
        qx_f  = s_qx_reg[NST];
        qy_f  = s_qy_reg[NST];
        tag_f = s_tag_reg[NST];
        sat_x = tag_f.neg_x ? (tag_f.ovf_x || qx_f > ppw_pkg::QUO_W'(ppw_pkg::SAT_NEG))
                            : (tag_f.ovf_x || qx_f > ppw_pkg::QUO_W'(ppw_pkg::SAT_POS));
        sat_y = tag_f.neg_y ? (tag_f.ovf_y || qy_f > ppw_pkg::QUO_W'(ppw_pkg::SAT_NEG))
                            : (tag_f.ovf_y || qy_f > ppw_pkg::QUO_W'(ppw_pkg::SAT_POS));
        if (tag_f.bad || sat_x) begin
            o_x_next = tag_f.neg_x ? ppw_pkg::SAT_NEG : ppw_pkg::SAT_POS;
        end else begin
            o_x_next = tag_f.neg_x ? ppw_pkg::COORD_W'(-qx_f) : ppw_pkg::COORD_W'(qx_f);
        end
        if (tag_f.bad || sat_y) begin
            o_y_next = tag_f.neg_y ? ppw_pkg::SAT_NEG : ppw_pkg::SAT_POS;
        end else begin
            o_y_next = tag_f.neg_y ? ppw_pkg::COORD_W'(-qy_f) : ppw_pkg::COORD_W'(qy_f);
        end
        o_clip_next = tag_f.bad || sat_x || sat_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_x_reg    <= o_x_next;
            o_y_reg    <= o_y_next;
            o_pe_reg   <= tag_f.poly_end;
            o_bad_reg  <= tag_f.bad;
            o_clip_reg <= o_clip_next;
        end
    end

    assign out_valid    = o_v_reg;
    assign warped_x     = o_x_reg;
    assign warped_y     = o_y_reg;
    assign out_poly_end = o_pe_reg;
    assign bad_divisor  = o_bad_reg;
    assign clipped      = o_clip_reg;

endmodule

// ===== hw/rtl/projective_point_warp.sv =====
// ----------------------------------------------------------------------------
// Projective point warp
// Applies a programmable 3x3 homography to a stream of Q16.16 points.
// ----------------------------------------------------------------------------
// Usage notes.
// Points arrive on the s_ channel as one word each: signed Q16.16 x and y
// and a polygon end mark. Every word yields exactly one result word on the
// m_ channel, in order: the warped point (X/w, Y/w) rounded to nearest with
// ties away from zero, the copied end mark, a flag for w at or below zero,
// and a flag for saturation of either coordinate.
// The eight matrix coefficients are signed Q16.32 and are written through
// cfg_wr_en, cfg_index and cfg_wr_data while no point is in flight.
// From acceptance to m_valid a word passes three multiply and sum stages,
// then two divider set-up stages, an overflow check, 33 restoring
// quotient stages (one bit each, set by the 33-bit quotient) and the output
// register. Throughput is one word per cycle while the output is not stalled.
// All stages advance together; when the output register holds a word that
// the receiver does not take, the whole pipeline holds and s_ready drops,
// so nothing is lost or repeated. An empty output register lets the
// pipeline move regardless of m_ready.
// Synchronous reset clears all valid bits and restores the identity matrix.
// ----------------------------------------------------------------------------
module projective_point_warp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ppw_pkg::COORD_W-1:0]    s_point_x,
    input  logic signed [ppw_pkg::COORD_W-1:0]    s_point_y,
    input  logic                                  s_poly_end,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ppw_pkg::COORD_W-1:0]    m_warped_x,
    output logic signed [ppw_pkg::COORD_W-1:0]    m_warped_y,
    output logic                                  m_poly_end_out,
    output logic                                  m_bad_divisor,
    output logic                                  m_clipped,
    input  logic                                  cfg_wr_en,
    input  logic [ppw_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [ppw_pkg::COEF_W-1:0]            cfg_wr_data
);

    ppw_pkg::coef_bank_t               coefs;
    logic                              en;
    logic                              mac_valid, mac_pe;
    logic signed [ppw_pkg::ACC_W-1:0]  mac_nx, mac_ny, mac_w;
    logic [ppw_pkg::COORD_W-1:0]       div_x, div_y;

    // The pipeline moves whenever the output register is free or being taken.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    ppw_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .coefs       (coefs)
    );

    // Numerators X, Y and the homogeneous coordinate w, exact.
    ppw_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .x            (s_point_x),
        .y            (s_point_y),
        .poly_end     (s_poly_end),
        .coefs        (coefs),
        .out_valid    (mac_valid),
        .nx           (mac_nx),
        .ny           (mac_ny),
        .w            (mac_w),
        .out_poly_end (mac_pe)
    );

    // Homogeneous divide with rounding and saturation.
    ppw_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (mac_valid),
        .nx           (mac_nx),
        .ny           (mac_ny),
        .w            (mac_w),
        .poly_end     (mac_pe),
        .out_valid    (m_valid),
        .warped_x     (div_x),
        .warped_y     (div_y),
        .out_poly_end (m_poly_end_out),
        .bad_divisor  (m_bad_divisor),
        .clipped      (m_clipped)
    );

    assign m_warped_x = $signed(div_x);
    assign m_warped_y = $signed(div_y);

endmodule

// ===== hw/rtl/ppw_checker.sv =====
// ----------------------------------------------------------------------------
// Projective point warp checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module ppw_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [ppw_pkg::COORD_W-1:0]    m_warped_x,
    input logic signed [ppw_pkg::COORD_W-1:0]    m_warped_y,
    input logic                                  m_poly_end_out,
    input logic                                  m_bad_divisor,
    input logic                                  m_clipped
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_warped_x) && $stable(m_warped_y)
                                && $stable(m_poly_end_out) && $stable(m_bad_divisor)
                                && $stable(m_clipped))
        else $error("result word changed while stalled");

    // With the output register empty the block must take input.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output register is empty");

    // A bad divisor always counts as clipped.
    a_bad_clips: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_divisor |-> m_clipped)
        else $error("bad divisor without clipped flag");

    // A bad divisor gives saturated coordinates.
    a_bad_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_divisor |->
            (m_warped_x == ppw_pkg::SAT_POS || m_warped_x == ppw_pkg::SAT_NEG) &&
            (m_warped_y == ppw_pkg::SAT_POS || m_warped_y == ppw_pkg::SAT_NEG))
        else $error("bad divisor with unsaturated output");

    // Nothing comes out in the first cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result word right after reset");

endmodule

bind projective_point_warp ppw_checker u_ppw_checker (.*);

// ===== sim/projective_point_warp_tb.sv =====
// ----------------------------------------------------------------------------
// Projective point warp testbench
// Streams Q16.16 points through the homography block under several matrix
// settings and checks every result word against a typed-in answer or predictor.
// ----------------------------------------------------------------------------
module projective_point_warp_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 40;
    localparam int WATCHDOG    = 20000;
    localparam int RANDOM_PTS  = 1750;

    // One result word as the block presents it.
    typedef struct packed {
        logic [31:0] wx;
        logic [31:0] wy;
        logic        pend;
        logic        bad;
        logic        clip;
    } warp_word_t;

    // One row of the directed table; has_exp marks a typed-in answer.
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        pend;
        logic        has_exp;
        warp_word_t  exp_word;
    } point_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic        s_poly_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_warped_x;
    logic signed [31:0] m_warped_y;
    logic        m_poly_end_out;
    logic        m_bad_divisor;
    logic        m_clipped;
    logic        cfg_wr_en = 1'b0;
    logic [ppw_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [ppw_pkg::COEF_W-1:0]    cfg_wr_data = '0;

    projective_point_warp dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the coefficient bank.
    logic signed [ppw_pkg::COEF_W-1:0] matrix [ppw_pkg::REG_COUNT];
    warp_word_t pending_warps[$];
    int  mismatches = 0;
    int  idle_pct_src = 0;
    int  idle_pct_snk = 0;
    bit  hold_sink = 1'b0;
    int  quiet_cycles = 0;

    // Rounded, saturated quotient num / den in Q16.16; den is positive.
    function automatic logic [31:0] divide_q16(logic signed [127:0] num,
                                               logic signed [127:0] den,
                                               ref logic clip);
        logic        neg;
        logic [127:0] mag;
        logic [127:0] quo;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = ((mag << (ppw_pkg::COORD_FRAC_BITS + 1)) + den) / (den << 1);
        if (!neg) begin
            if (quo > 128'h7FFF_FFFF) begin
                clip = 1'b1;
                return ppw_pkg::SAT_POS;
            end
            return quo[31:0];
        end
        if (quo > 128'h8000_0000) begin
            clip = 1'b1;
            return ppw_pkg::SAT_NEG;
        end
        return -quo[31:0];
    endfunction

    function automatic warp_word_t warp_point(logic signed [31:0] x,
                                              logic signed [31:0] y, logic pend);
        logic signed [127:0] nx, ny, w;
        warp_word_t r;
        logic clip;
        clip = 1'b0;
        nx = 128'(matrix[ppw_pkg::REG_SCALE_XX]) * 128'(x)
           + 128'(matrix[ppw_pkg::REG_SHEAR_XY]) * 128'(y)
           + (128'(matrix[ppw_pkg::REG_SHIFT_X]) <<< ppw_pkg::COORD_FRAC_BITS);
        ny = 128'(matrix[ppw_pkg::REG_SHEAR_YX]) * 128'(x)
           + 128'(matrix[ppw_pkg::REG_SCALE_YY]) * 128'(y)
           + (128'(matrix[ppw_pkg::REG_SHIFT_Y]) <<< ppw_pkg::COORD_FRAC_BITS);
        w  = 128'(matrix[ppw_pkg::REG_PERSP_X]) * 128'(x)
           + 128'(matrix[ppw_pkg::REG_PERSP_Y]) * 128'(y)
           + (128'sd1 <<< (ppw_pkg::COEF_FRAC_BITS + ppw_pkg::COORD_FRAC_BITS));
        r.pend = pend;
        r.bad  = (w <= 0);
        if (r.bad) begin
            clip = 1'b1;
            r.wx = (nx < 0) ? ppw_pkg::SAT_NEG : ppw_pkg::SAT_POS;
            r.wy = (ny < 0) ? ppw_pkg::SAT_NEG : ppw_pkg::SAT_POS;
        end else begin
            r.wx = divide_q16(nx, w, clip);
            r.wy = divide_q16(ny, w, clip);
        end
        r.clip = clip;
        return r;
    endfunction

    // Register writes go to the block and the predictor together. The write
    // enable stays high across a run of writes and load_matrix drops it.
    task automatic write_coef(ppw_pkg::ppw_reg_t idx, logic [ppw_pkg::COEF_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        matrix[idx] = val;
    endtask

    task automatic load_matrix(logic [ppw_pkg::COEF_W-1:0] m0,
                               logic [ppw_pkg::COEF_W-1:0] m1,
                               logic [ppw_pkg::COEF_W-1:0] m2,
                               logic [ppw_pkg::COEF_W-1:0] m3,
                               logic [ppw_pkg::COEF_W-1:0] m4,
                               logic [ppw_pkg::COEF_W-1:0] m5,
                               logic [ppw_pkg::COEF_W-1:0] m6,
                               logic [ppw_pkg::COEF_W-1:0] m7);
        write_coef(ppw_pkg::REG_SCALE_XX, m0);
        write_coef(ppw_pkg::REG_SHEAR_XY, m1);
        write_coef(ppw_pkg::REG_SHIFT_X,  m2);
        write_coef(ppw_pkg::REG_SHEAR_YX, m3);
        write_coef(ppw_pkg::REG_SCALE_YY, m4);
        write_coef(ppw_pkg::REG_SHIFT_Y,  m5);
        write_coef(ppw_pkg::REG_PERSP_X,  m6);
        write_coef(ppw_pkg::REG_PERSP_Y,  m7);
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one point word and holds it until accepted. The expectation is
    // queued at the accepting edge so it is always in place before the result.
    // Valid stays high after acceptance; the next offer or an idle cycle
    // drops it.
    task automatic offer_point(logic [31:0] x, logic [31:0] y, logic pend,
                               logic has_exp, warp_word_t typed);
        while (idle_pct_src != 0 && $urandom_range(99, 0) < idle_pct_src) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_point_x  <= x;
        s_point_y  <= y;
        s_poly_end <= pend;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_warps.insert(pending_warps.size(),
                             has_exp ? typed : warp_point(x, y, pend));
    endtask

    // Waits until the queue drains, then lets the pipeline settle.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_warps.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Mostly moderate coordinates so the quotient often lands in range;
    // sometimes full-range words so every bit is exercised.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3, 0))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(2000000, 0)) - 1000000);
            default: return 32'($signed($urandom_range(20000000, 0)) - 10000000);
        endcase
    endfunction

    function automatic logic [ppw_pkg::COEF_W-1:0] pick_coef(int mag_bits);
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        v = v & ((64'd1 << mag_bits) - 1);
        if ($urandom_range(1, 0)) v = -v;
        return v[ppw_pkg::COEF_W-1:0];
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_sink &&
                       !(idle_pct_snk != 0 && $urandom_range(99, 0) < idle_pct_snk);
        end
    end

    // Scoreboard: compares each accepted word with the oldest expectation.
    always @(posedge aclk) begin
        warp_word_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_warped_x, m_warped_y, m_poly_end_out, m_bad_divisor, m_clipped};
            if (pending_warps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: %h", got);
            end else begin
                want = pending_warps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Result mismatch: expected x=%h y=%h e=%b b=%b c=%b,",
                                  " got x=%h y=%h e=%b b=%b c=%b"},
                                 want.wx, want.wy, want.pend, want.bad, want.clip,
                                 got.wx, got.wy, got.pend, got.bad, got.clip);
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Identity after reset gives results that can be read off directly.
    point_row_t directed [] = '{
        '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1,
          '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0}},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1,
          '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
        '{32'h0000_0001, 32'h1234_5678, 1'b0, 1'b0, '{default: '0}}
    };

    // Rows run after the matrix changes; the predictor supplies the answer.
    point_row_t warped_rows [] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{default: '0}},
        '{32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0, '{default: '0}},
        '{32'hFFFF_0000, 32'h0003_8000, 1'b0, 1'b0, '{default: '0}},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, '{default: '0}},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '{default: '0}},
        '{32'hFFFE_0000, 32'h0000_0000, 1'b0, 1'b0, '{default: '0}},
        '{32'h0000_8000, 32'hFFFF_8000, 1'b1, 1'b0, '{default: '0}},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, '{default: '0}}
    };

    initial begin
        matrix = '{ppw_pkg::COEF_ONE, ppw_pkg::COEF_ZERO, ppw_pkg::COEF_ZERO,
                   ppw_pkg::COEF_ZERO, ppw_pkg::COEF_ONE, ppw_pkg::COEF_ZERO,
                   ppw_pkg::COEF_ZERO, ppw_pkg::COEF_ZERO};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the reset matrix, then through several matrices:
        // half scale with offsets, w crossing zero at x = -1 (bad divisor),
        // and the coefficient extremes that force saturation.
        foreach (directed[i])
            offer_point(directed[i].x, directed[i].y, directed[i].pend,
                        directed[i].has_exp, directed[i].exp_word);
        drain_pipeline();
        load_matrix(48'h0000_8000_0000, 48'h0000_4000_0000, 48'h0003_0000_0001,
                    48'hFFFF_C000_0000, 48'h0000_8000_0000, 48'hFFFD_0000_0000,
                    48'h0000_0000_0000, 48'h0000_0000_0000);
        foreach (warped_rows[i])
            offer_point(warped_rows[i].x, warped_rows[i].y, warped_rows[i].pend,
                        1'b0, '0);
        drain_pipeline();
        load_matrix(48'h0002_0000_0000, 48'hFFFF_0000_0000, 48'h0000_0000_0000,
                    48'h0000_0000_0000, 48'hFFFE_0000_0000, 48'h0001_0000_0000,
                    48'h0001_0000_0000, 48'h0000_0000_0000);
        foreach (warped_rows[i])
            offer_point(warped_rows[i].x, warped_rows[i].y, warped_rows[i].pend,
                        1'b0, '0);
        drain_pipeline();
        load_matrix(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                    48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                    48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        foreach (warped_rows[i])
            offer_point(warped_rows[i].x, warped_rows[i].y, warped_rows[i].pend,
                        1'b0, '0);
        drain_pipeline();

        // Random phases: each gets a fresh matrix. Small coefficient sizes
        // dominate so that many quotients stay in range.
        for (int phase = 0; phase < 14; phase++) begin
            case (phase % 3)
                0: begin idle_pct_src = 34; idle_pct_snk = 61; end
                1: begin idle_pct_src = 61; idle_pct_snk = 34; end
                default: begin idle_pct_src = 0; idle_pct_snk = 0; end
            endcase
            if (phase >= 9) begin
                idle_pct_src = 0;
                idle_pct_snk = 0;
            end
            if (phase == 13) begin
                load_matrix(ppw_pkg::COEF_ONE, ppw_pkg::COEF_ZERO, ppw_pkg::COEF_ZERO,
                            ppw_pkg::COEF_ZERO, ppw_pkg::COEF_ONE, ppw_pkg::COEF_ZERO,
                            ppw_pkg::COEF_ZERO, ppw_pkg::COEF_ZERO);
            end else begin
                load_matrix(pick_coef(34), pick_coef(31), pick_coef(47),
                            pick_coef(31), pick_coef(34), pick_coef(47),
                            pick_coef(phase % 2 ? 14 : 20),
                            pick_coef(phase % 2 ? 14 : 20));
            end
            // Long receiver hold-off while points keep coming, in phase 2.
            if (phase == 2) begin
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < RANDOM_PTS / 14; n++) begin
                offer_point(pick_coord(), pick_coord(), 1'($urandom()), 1'b0, '0);
                // The sender sometimes waits until every result is back.
                if (n == 40) begin
                    s_valid <= 1'b0;
                    while (pending_warps.size() != 0) @(posedge aclk);
                end
            end
            drain_pipeline();
        end

        if (mismatches == 0 && pending_warps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== projective_point_warp.f =====
hw/rtl/ppw_pkg.sv
hw/rtl/ppw_cfg_regs.sv
hw/rtl/ppw_mac.sv
hw/rtl/ppw_div.sv
hw/rtl/projective_point_warp.sv
hw/rtl/ppw_checker.sv
sim/projective_point_warp_tb.sv
